// ===== src/u8dec_pkg.sv =====
// shared types, constants and value checks for the utf-8 code point decoder
package u8dec_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [30:0] MAX_SCALAR       = 31'h0010FFFF;
   localparam logic [30:0] SURR_LOW         = 31'h0000D800;
   localparam logic [30:0] SURR_HIGH        = 31'h0000DFFF;
   localparam logic [30:0] NONCHAR_FFFE     = 31'h0000FFFE;
   localparam logic [30:0] NONCHAR_FFFF     = 31'h0000FFFF;
   localparam logic [30:0] BOM_VALUE        = 31'h0000FEFF;
   localparam logic [1:0]  CONT_TAG         = 2'b10;

   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_MULTI,
      LEAD_BAD
   } lead_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        substituted;
   } slot_type;

   // one or two results caused by one request
   typedef struct packed {
      logic     two;
      slot_type first;
      slot_type second;
   } record_type;

   typedef struct packed {
      logic     valid;
      slot_type slot;
   } check_type;

   function automatic check_type check_value(input logic [30:0] v, input logic drop_bom);
      check_type r;
      r.valid = 1'b1;
      r.slot.code_point = v[20:0];
      r.slot.substituted = 1'b0;
      if ((v >= SURR_LOW && v <= SURR_HIGH) || v == NONCHAR_FFFE ||
          v == NONCHAR_FFFF || v > MAX_SCALAR) begin
         r.slot.code_point = REPLACEMENT_CHAR;
         r.slot.substituted = 1'b1;
      end else if (v == BOM_VALUE && drop_bom) begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/u8dec_front.sv =====
// front end: accepts bytes, tracks the open sequence and builds result records
module u8dec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic                   req_fire,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   output logic                   push,
   output u8dec_pkg::record_type  push_record
);

   logic                  drop_bom_ff;
   logic [30:0]           partial_ff;
   logic [30:0]           partial_in;
   logic [2:0]            remaining_ff;
   logic [2:0]            remaining_in;

   u8dec_pkg::lead_type   lead_kind;
   logic [4:0]            lead_val;
   logic [2:0]            lead_due;
   logic                  is_cont;
   logic [30:0]           shifted;
   logic [2:0]            rem_dec;
   logic                  pre_repl;
   logic                  main_repl;
   logic                  main_emit;
   logic [30:0]           emit_val;
   u8dec_pkg::check_type  chk;
   logic                  main_valid;
   u8dec_pkg::slot_type   main_slot;
   u8dec_pkg::slot_type   repl_slot;

   always_comb begin
      lead_val = 5'd0;
      lead_due = 3'd0;
      case (data_byte) inside
         [8'h00:8'h7F]: begin
            lead_kind = u8dec_pkg::LEAD_ASCII;
         end
         [8'hC0:8'hDF]: begin
            lead_kind = u8dec_pkg::LEAD_MULTI;
            lead_val = data_byte[4:0];
            lead_due = 3'd1;
         end
         [8'hE0:8'hEF]: begin
            lead_kind = u8dec_pkg::LEAD_MULTI;
            lead_val = {1'b0, data_byte[3:0]};
            lead_due = 3'd2;
         end
         [8'hF0:8'hF7]: begin
            lead_kind = u8dec_pkg::LEAD_MULTI;
            lead_val = {2'b0, data_byte[2:0]};
            lead_due = 3'd3;
         end
         [8'hF8:8'hFB]: begin
            lead_kind = u8dec_pkg::LEAD_MULTI;
            lead_val = {3'b0, data_byte[1:0]};
            lead_due = 3'd4;
         end
         8'hFC, 8'hFD: begin
            lead_kind = u8dec_pkg::LEAD_MULTI;
            lead_val = {4'b0, data_byte[0]};
            lead_due = 3'd5;
         end
         default: begin
            lead_kind = u8dec_pkg::LEAD_BAD;
         end
      endcase
   end

   assign is_cont = (data_byte[7:6] == u8dec_pkg::CONT_TAG);
   assign shifted = {partial_ff[24:0], data_byte[5:0]};
   assign rem_dec = remaining_ff - 3'd1;

   always_comb begin
      partial_in = partial_ff;
      remaining_in = remaining_ff;
      pre_repl = 1'b0;
      main_repl = 1'b0;
      main_emit = 1'b0;
      emit_val = shifted;
      if (remaining_ff != 3'd0 && is_cont) begin
         if (rem_dec == 3'd0) begin
            main_emit = 1'b1;
            partial_in = '0;
            remaining_in = '0;
         end else if (final_byte) begin
            main_repl = 1'b1;
            partial_in = '0;
            remaining_in = '0;
         end else begin
            partial_in = shifted;
            remaining_in = rem_dec;
         end
      end else begin
         pre_repl = (remaining_ff != 3'd0);
         partial_in = '0;
         remaining_in = '0;
         unique case (lead_kind)
            u8dec_pkg::LEAD_ASCII: begin
               main_emit = 1'b1;
               emit_val = {23'd0, data_byte};
            end
            u8dec_pkg::LEAD_MULTI: begin
               if (final_byte) begin
                  main_repl = 1'b1;
               end else begin
                  partial_in = {26'd0, lead_val};
                  remaining_in = lead_due;
               end
            end
            default: begin
               main_repl = 1'b1;
            end
         endcase
      end
   end

   assign chk = u8dec_pkg::check_value(emit_val, drop_bom_ff);
   assign repl_slot.code_point = u8dec_pkg::REPLACEMENT_CHAR;
   assign repl_slot.substituted = 1'b1;

   always_comb begin
      main_valid = main_repl || (main_emit && chk.valid);
      main_slot = main_repl ? repl_slot : chk.slot;
      if (pre_repl) begin
         push_record.first = repl_slot;
         push_record.second = main_slot;
         push_record.two = main_valid;
      end else begin
         push_record.first = main_slot;
         push_record.second = main_slot;
         push_record.two = 1'b0;
      end
   end

   assign push = req_fire && (pre_repl || main_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_bom_ff <= 1'b1;
         partial_ff <= '0;
         remaining_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            drop_bom_ff <= csr_write_data;
         end
         if (req_fire) begin
            partial_ff <= partial_in;
            remaining_ff <= remaining_in;
         end
      end
   end

endmodule

// ===== src/u8dec_queue.sv =====
// short record queue between front end and output stage
module u8dec_queue #(
   parameter int unsigned DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  u8dec_pkg::record_type  push_record,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output u8dec_pkg::record_type  head_record
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   u8dec_pkg::record_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_record = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/u8dec_back.sv =====
// output stage: walks each record's results into the response register
module u8dec_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  u8dec_pkg::record_type  head_record,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [20:0]            code_point,
   output logic                   substituted,
   output logic                   run_end
);

   logic                  phase_ff;
   logic                  out_valid_ff;
   logic [20:0]           out_cp_ff;
   logic                  out_sub_ff;
   logic                  out_last_ff;
   logic                  load;
   logic                  slot_last;
   u8dec_pkg::slot_type   slot;

   assign load = head_valid && (!out_valid_ff || rsp_tready);
   assign slot = phase_ff ? head_record.second : head_record.first;
   assign slot_last = phase_ff || !head_record.two;
   assign pop = load && slot_last;

   always_ff @(posedge clock) begin
      if (load) begin
         out_cp_ff <= slot.code_point;
         out_sub_ff <= slot.substituted;
         out_last_ff <= slot_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff <= !slot_last;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign code_point = out_cp_ff;
   assign substituted = out_sub_ff;
   assign run_end = out_last_ff;

endmodule

// ===== src/utf8_code_point_decoder.sv =====
// top level of the utf-8 code point decoder
//
// req channel carries one byte of a utf-8 string per request, tlast on the
// string's final byte. rsp channel carries decoded code points, tuser set
// when the value is a substituted U+FFFD, tlast on the last result that a
// request caused. a request gives zero, one or two results.
// csr_write_enable/csr_write_data set the byte-order-mark drop flag; write
// it only while the block is idle.
// a request's record goes through the record queue to the output register.
// throughput: one request per cycle and one result per cycle; a request
// that yields two results holds the output register for both in turn, and
// the record queue between front end and output stage (QUEUE_DEPTH deep)
// absorbs that. req_tready drops only when the queue is full.
// when rsp_tready is low the output register holds; requests keep being
// taken until the queue fills.
// reset clears the open sequence, empties the queue and sets the drop flag.
module utf8_code_point_decoder #(
   parameter int unsigned QUEUE_DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [0:0]  rsp_tuser,   // [0] substituted
   output logic        rsp_tlast
);

   logic                   full;
   logic                   req_fire;
   logic                   push;
   u8dec_pkg::record_type  push_record;
   logic                   head_valid;
   u8dec_pkg::record_type  head_record;
   logic                   pop;
   logic [20:0]            code_point;
   logic                   substituted;

   assign req_tready = !full;
   assign req_fire = req_tvalid && req_tready;

   u8dec_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_fire         (req_fire),
      .data_byte        (req_tdata),
      .final_byte       (req_tlast),
      .push             (push),
      .push_record      (push_record)
   );

   u8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_record (push_record),
      .full        (full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_record (head_record)
   );

   u8dec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_record (head_record),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .code_point  (code_point),
      .substituted (substituted),
      .run_end     (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, code_point};
   assign rsp_tuser = substituted;

endmodule

// ===== bench/utf8_code_point_decoder_tb.sv =====
// self-checking testbench for the utf-8 code point decoder
`timescale 1ns / 1ps

module utf8_code_point_decoder_tb;

   localparam int unsigned CLOCK_HALF = 4;
   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LONG_HOLD = 250;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_BYTES = 420;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
      logic [2:0] gap;
      logic       drain;
   } request_item_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        substituted;
      logic        run_end;
   } code_point_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [20:0] code_point, [23:21] zero
   logic [0:0]  rsp_tuser;           // [0] substituted
   logic        rsp_tlast;

   utf8_code_point_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast)
   );

   always #(CLOCK_HALF) clock = ~clock;

   request_item_type      pending_requests[$];
   code_point_result_type expected_results[$];
   code_point_result_type step_out[$];

   // decoder state mirrored by the predictor
   logic [30:0] seq_value = '0;
   logic [2:0]  seq_due = '0;
   logic        drop_bom = 1'b1;

   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned requests_accepted = 0;
   int unsigned two_result_requests = 0;
   int unsigned substitutions = 0;
   int unsigned strings_built = 0;
   int unsigned drop_flag_writes = 0;
   int unsigned cycle_count = 0;

   function automatic void add_result(logic [20:0] cp, logic sub);
      code_point_result_type r;
      r.code_point = cp;
      r.substituted = sub;
      r.run_end = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void add_value(logic [30:0] v);
      if ((v >= u8dec_pkg::SURR_LOW && v <= u8dec_pkg::SURR_HIGH) ||
          v == u8dec_pkg::NONCHAR_FFFE || v == u8dec_pkg::NONCHAR_FFFF ||
          v > u8dec_pkg::MAX_SCALAR) begin
         add_result(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
      end else if (!(v == u8dec_pkg::BOM_VALUE && drop_bom)) begin
         add_result(v[20:0], 1'b0);
      end
   endfunction

   function automatic void take_lead_byte(logic [7:0] b, logic fin);
      logic [30:0] v;
      logic [2:0]  due;
      v = '0;
      due = '0;
      casez (b)
         8'b0???????: begin
            add_value({23'b0, b});
            return;
         end
         8'b110?????: begin v = 31'(b[4:0]); due = 3'd1; end
         8'b1110????: begin v = 31'(b[3:0]); due = 3'd2; end
         8'b11110???: begin v = 31'(b[2:0]); due = 3'd3; end
         8'b111110??: begin v = 31'(b[1:0]); due = 3'd4; end
         8'b1111110?: begin v = 31'(b[0]);   due = 3'd5; end
         default: begin
            add_result(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
            return;
         end
      endcase
      if (fin) begin
         add_result(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
         seq_value = '0;
         seq_due = '0;
      end else begin
         seq_value = v;
         seq_due = due;
      end
   endfunction

   function automatic void predict_request(logic [7:0] b, logic fin);
      code_point_result_type r;
      step_out.delete();
      if (seq_due != 0) begin
         if (b[7:6] == u8dec_pkg::CONT_TAG) begin
            seq_value = {seq_value[24:0], b[5:0]};
            seq_due = seq_due - 3'd1;
            if (seq_due == 0) begin
               add_value(seq_value);
               seq_value = '0;
            end else if (fin) begin
               add_result(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
               seq_value = '0;
               seq_due = '0;
            end
         end else begin
            // broken sequence: close it, then decode the byte as a lead
            add_result(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
            seq_value = '0;
            seq_due = '0;
            take_lead_byte(b, fin);
         end
      end else begin
         take_lead_byte(b, fin);
      end
      if (step_out.size() == 2) two_result_requests++;
      foreach (step_out[i]) begin
         r = step_out[i];
         r.run_end = (i == step_out.size() - 1);
         if (r.substituted) substitutions++;
         expected_results.insert(expected_results.size(), r);
      end
   endfunction

   // request driver
   request_item_type next_item;
   logic             have_item = 1'b0;
   int unsigned      gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         have_item = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_request(req_tdata, req_tlast);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (!have_item && pending_requests.size() != 0) begin
               next_item = pending_requests.pop_front();
               have_item = 1'b1;
               gap_left = next_item.gap;
            end
            if (have_item && gap_left == 0 &&
                !(next_item.drain && expected_results.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata <= next_item.data_byte;
               req_tlast <= next_item.final_byte;
               have_item = 1'b0;
            end else begin
               req_tvalid <= 1'b0;
               if (have_item && gap_left != 0) gap_left--;
            end
         end
      end
   end

   // result monitor and checker
   code_point_result_type want;
   int unsigned           rx_wait = 0;
   logic                  rx_quiet;
   logic                  bad;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: tdata=%h tuser=%b tlast=%b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               bad = 1'b0;
               if (rsp_tdata !== {3'b000, want.code_point}) bad = 1'b1;
               if (rsp_tuser[0] !== want.substituted) bad = 1'b1;
               if (rsp_tlast !== want.run_end) bad = 1'b1;
               if (bad) begin
                  if (error_count < 10)
                     $display("mismatch on result %0d: expected cp=%h sub=%b last=%b, got %s",
                              results_checked, want.code_point, want.substituted,
                              want.run_end,
                              $sformatf("tdata=%h tuser=%b tlast=%b",
                                        rsp_tdata, rsp_tuser, rsp_tlast));
                  error_count++;
               end
            end
            rx_quiet = ((results_checked / 64) % 4) == 3;
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 4);
            if (results_checked % 500 == 250) rx_wait = LONG_HOLD;
         end
         if (rx_wait != 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("** utf8_code_point_decoder: FAILED **");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fin, input logic quiet,
                            input logic drain);
      request_item_type it;
      it.data_byte = b;
      it.final_byte = fin;
      it.gap = quiet ? 3'd0 : 3'($urandom_range(0, 4));
      it.drain = drain;
      pending_requests.insert(pending_requests.size(), it);
   endtask

   task automatic append_encoded(ref logic [7:0] seq[$], input logic [30:0] v,
                                 input int len);
      logic [7:0] prefix;
      logic [7:0] mask;
      case (len)
         1: begin prefix = 8'h00; mask = 8'h7F; end
         2: begin prefix = 8'hC0; mask = 8'h1F; end
         3: begin prefix = 8'hE0; mask = 8'h0F; end
         4: begin prefix = 8'hF0; mask = 8'h07; end
         5: begin prefix = 8'hF8; mask = 8'h03; end
         default: begin prefix = 8'hFC; mask = 8'h01; end
      endcase
      seq.insert(seq.size(), prefix | (8'(v >> (6 * (len - 1))) & mask));
      for (int i = len - 2; i >= 0; i--)
         seq.insert(seq.size(), 8'h80 | (8'(v >> (6 * i)) & 8'h3F));
   endtask

   function automatic logic [30:0] special_value(input int unsigned pick);
      case (pick)
         0: return 31'h00FEFF;
         1: return 31'h00FFFD;
         2: return 31'h00FFFE;
         3: return 31'h00FFFF;
         4: return 31'h00D800;
         5: return 31'h00DFFF;
         6: return 31'h00D7FF;
         7: return 31'h00E000;
         8: return 31'h10FFFF;
         9: return 31'h110000;
         10: return 31'h1FFFFF;
         default: return 31'h010000;
      endcase
   endfunction

   // one string: mostly well-formed sequences, some cut short and some noise
   task automatic build_string(input logic quiet, input logic drain);
      logic [7:0]  seq[$];
      logic [7:0]  part[$];
      logic [30:0] v;
      int          units;
      int unsigned kind;
      int unsigned r;
      int          len;
      int          keep;
      units = $urandom_range(1, 6);
      for (int u = 0; u < units; u++) begin
         kind = $urandom_range(0, 99);
         r = $urandom_range(0, 9);
         len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : (r == 8) ? 4 : $urandom_range(5, 6);
         if (kind < 60) begin
            v = 31'($urandom() >> (32 - (len == 1 ? 7 : 5 * len + 1)));
            append_encoded(seq, v, len);
         end else if (kind < 70) begin
            v = special_value($urandom_range(0, 11));
            append_encoded(seq, v, (v > 31'h00FFFF) ? 4 : 3);
         end else if (kind < 82) begin
            part.delete();
            len = $urandom_range(2, 6);
            append_encoded(part, 31'($urandom() >> (32 - (5 * len + 1))), len);
            keep = $urandom_range(1, len - 1);
            for (int i = 0; i < keep; i++) seq.insert(seq.size(), part[i]);
         end else begin
            seq.insert(seq.size(), 8'($urandom_range(0, 255)));
         end
      end
      foreach (seq[i])
         push_byte(seq[i], i == seq.size() - 1, quiet, drain && i == 0);
      strings_built++;
   endtask

   task automatic load_random_strings(input int unsigned byte_target);
      int unsigned start;
      int unsigned n;
      start = pending_requests.size();
      n = 0;
      while (pending_requests.size() - start < byte_target) begin
         build_string((n % 40) >= 32, n == 25);
         n++;
      end
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || have_item || req_tvalid ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_drop_flag(input logic v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      drop_bom = v;
      drop_flag_writes++;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ascii extremes, two/three/four byte forms, dropped bom, range limits
      push_byte(8'h00, 1'b1, 1'b0, 1'b0);
      push_byte(8'h7F, 1'b1, 1'b0, 1'b0);
      push_byte(8'hC2, 1'b0, 1'b0, 1'b0);
      push_byte(8'hA9, 1'b1, 1'b0, 1'b0);
      push_byte(8'hEF, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBB, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBF, 1'b1, 1'b0, 1'b0);
      push_byte(8'hED, 1'b0, 1'b0, 1'b0);
      push_byte(8'hA0, 1'b0, 1'b0, 1'b0);
      push_byte(8'h80, 1'b1, 1'b0, 1'b0);
      push_byte(8'hEF, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBF, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBD, 1'b1, 1'b0, 1'b0);
      push_byte(8'hF4, 1'b0, 1'b0, 1'b0);
      push_byte(8'h90, 1'b0, 1'b0, 1'b0);
      push_byte(8'h80, 1'b0, 1'b0, 1'b0);
      push_byte(8'h80, 1'b1, 1'b0, 1'b0);
      // bad leads
      push_byte(8'h80, 1'b1, 1'b0, 1'b0);
      push_byte(8'hFE, 1'b0, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0, 1'b0);
      // broken sequence, then strings cut short on a lead and on a continuation
      push_byte(8'hE2, 1'b0, 1'b0, 1'b0);
      push_byte(8'h41, 1'b1, 1'b0, 1'b0);
      push_byte(8'hC3, 1'b1, 1'b0, 1'b0);
      push_byte(8'hE2, 1'b0, 1'b0, 1'b0);
      push_byte(8'h82, 1'b1, 1'b0, 1'b0);
      wait_idle();

      write_drop_flag(1'b0);
      push_byte(8'hEF, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBB, 1'b0, 1'b0, 1'b0);
      push_byte(8'hBF, 1'b1, 1'b0, 1'b0);
      load_random_strings(PHASE_BYTES);
      wait_idle();

      write_drop_flag(1'b1);
      load_random_strings(PHASE_BYTES);
      wait_idle();

      write_drop_flag(1'b0);
      load_random_strings(PHASE_BYTES);
      wait_idle();

      $display("%0d byte requests in %0d strings gave %0d code points checked",
               requests_accepted, strings_built, results_checked);
      $display("%0d substitutions, %0d double-result requests, %0d drop flag writes",
               substitutions, two_result_requests, drop_flag_writes);
      if (error_count == 0) begin
         $display("** utf8_code_point_decoder: PASSED **");
      end else begin
         $display("%0d errors", error_count);
         $display("** utf8_code_point_decoder: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/u8dec_pkg.sv
src/u8dec_front.sv
src/u8dec_queue.sv
src/u8dec_back.sv
src/utf8_code_point_decoder.sv
bench/utf8_code_point_decoder_tb.sv
